/* src/assert_macros.svh */
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property a implies b on the same edge
`define ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Property a implies b on the next edge
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

/* src/scsa_pkg.sv */
`default_nettype none
package scsa_pkg;
   localparam int NUM_CLASSES       = 8;
   localparam int BUCKETS_PER_CLASS = 4;
   localparam int MIN_BLOCK_LOG2    = 4;
   localparam int MAX_BLOCKS        = 256;
   localparam int REGION_LOG2       = 19;
   localparam int WORDS_PER_BUCKET  = (MAX_BLOCKS + 63) / 64;
   localparam int NUM_BUCKETS       = NUM_CLASSES * BUCKETS_PER_CLASS;
   localparam int NUM_WORDS         = NUM_BUCKETS * WORDS_PER_BUCKET;
   localparam int WADDR_W           = $clog2(NUM_WORDS);
   localparam int WSEL_W            = $clog2(WORDS_PER_BUCKET);
   localparam int SLOT_W            = $clog2(NUM_BUCKETS);
   localparam int BSEL_W            = $clog2(BUCKETS_PER_CLASS);

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_SPACE    = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE   = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR    = 3'd3;
   localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic        command;
      logic [15:0] req_length;
      logic [3:0]  align_log2;
      logic [23:0] free_address;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [23:0] block_address;
      logic [2:0]  size_class;
      logic [7:0]  block_index;
   } rsp_type;

   typedef struct packed {
      logic       too_large;
      logic [2:0] cls;
   } class_type;
endpackage
`default_nettype wire

/* src/size_class_slab_allocator_unit.sv */
`default_nettype none
// Size-class slab allocator.
// req_* carries one request (alloc or free); rsp_* returns one response per
// request, in order. Both channels move a request when valid is high and
// stall is low. csr_* writes the per-class block counts (index 0..7) and
// must only be used while idle.
// Allocation walks the buckets of the class in order and the 64-bit words of
// each bucket, one word read from the bitmap RAM at a time (address in
// S_READ, then registered data checked in S_CHECK), for at most four buckets
// of four words. A free reads one word and, for a good address of a block in
// use, writes it back. Requests that are too large skip the bitmap and go
// straight to S_DONE.
// The response sits in an output register; the next request is taken once it
// has been delivered. A stalled response simply holds.
// Reset (synchronous, active high) restores the counts and runs a clearing
// pass over the bitmap RAM, one word per cycle (NUM_WORDS = 128 words),
// during which no request is accepted. Used counts are kept per bucket in a
// small RAM read beside the bitmap word and zeroed by the same pass.
`include "assert_macros.svh"
module size_class_slab_allocator_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire scsa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output scsa_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [8:0]        csr_wdata
);
   localparam int WA = scsa_pkg::WADDR_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_CHECK, S_WRITE, S_DONE
   } state_type;

   state_type state_ff;
   logic [8:0] count_ff [scsa_pkg::NUM_CLASSES];
   scsa_pkg::req_type req_ff;
   scsa_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic [2:0] cls_ff;
   logic [WA-1:0] clr_ff;
   logic [scsa_pkg::BSEL_W-1:0] bkt_ff;
   logic [scsa_pkg::WSEL_W-1:0] wrd_ff;
   logic [63:0] wdata_ff;
   logic [WA-1:0] waddr_ff;

   scsa_pkg::class_type cls_res;
   scsa_classify u_class (
      .req_length(req_data.req_length),
      .align_log2(req_data.align_log2),
      .result(cls_res)
   );

   // free decoding from the latched request
   logic [8:0] eff_n;
   logic [23:0] faddr;
   logic [scsa_pkg::REGION_LOG2-1:0] foff;
   logic [23-scsa_pkg::REGION_LOG2:0] fregion;
   logic [scsa_pkg::REGION_LOG2-1:0] fidx_full;
   logic fgood;
   logic [7:0] fidx;
   logic [scsa_pkg::SLOT_W-1:0] slot;
   logic [WA-1:0] rd_addr;
   logic [63:0] rd_data;
   logic wr_en;
   logic [WA-1:0] wr_addr;
   logic [63:0] wr_data;
   logic [63:0] valid_mask;
   logic found;
   logic [5:0] found_bit;
   logic [8:0] used_rd;
   logic [8:0] used_wr;
   logic [scsa_pkg::SLOT_W-1:0] used_wr_addr;

   always_comb begin
      eff_n = (count_ff[cls_ff] > 9'(scsa_pkg::MAX_BLOCKS)) ?
              9'(scsa_pkg::MAX_BLOCKS) : count_ff[cls_ff];
      faddr = req_ff.free_address;
      foff = faddr[scsa_pkg::REGION_LOG2-1:0];
      fregion = faddr[23:scsa_pkg::REGION_LOG2];
      fidx_full = foff >> (scsa_pkg::MIN_BLOCK_LOG2 + cls_ff);
      fgood = (fregion[23-scsa_pkg::REGION_LOG2:scsa_pkg::BSEL_W] == 
               (24-scsa_pkg::REGION_LOG2-scsa_pkg::BSEL_W)'(cls_ff)) &&
              ((foff & ((scsa_pkg::REGION_LOG2)'(1) <<
                (scsa_pkg::MIN_BLOCK_LOG2 + cls_ff)) - 1'b1) == '0) &&
              (fidx_full < (scsa_pkg::REGION_LOG2)'(eff_n));
      fidx = fidx_full[7:0];
      if (req_ff.command == scsa_pkg::CMD_FREE)
         slot = fregion[scsa_pkg::SLOT_W-1:0];
      else
         slot = {cls_ff, bkt_ff};
      if (req_ff.command == scsa_pkg::CMD_FREE)
         rd_addr = {slot, fidx[7:6]};
      else
         rd_addr = {slot, wrd_ff};
      for (int j = 0; j < 64; j++)
         valid_mask[j] = ({1'b0, wrd_ff, 6'(j)} < eff_n);
      found = 1'b0;
      found_bit = '0;
      for (int j = 63; j >= 0; j--) begin
         if (rd_data[j] && valid_mask[j]) begin
            found = 1'b1;
            found_bit = 6'(j);
         end
      end
      wr_en = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
      wr_addr = (state_ff == S_CLEAR) ? clr_ff : waddr_ff;
      wr_data = (state_ff == S_CLEAR) ? '1 : wdata_ff;
      // used count of the slot is read in S_CHECK and written back in S_WRITE
      used_wr_addr = (state_ff == S_CLEAR) ? clr_ff[scsa_pkg::SLOT_W-1:0] : slot;
      if (state_ff == S_CLEAR)
         used_wr = '0;
      else if (req_ff.command == scsa_pkg::CMD_FREE)
         used_wr = (used_rd != '0) ? used_rd - 9'd1 : used_rd;
      else
         used_wr = (used_rd != 9'd511) ? used_rd + 9'd1 : used_rd;
   end

   scsa_ram #(.WIDTH(64), .DEPTH(scsa_pkg::NUM_WORDS)) u_bitmap (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   scsa_ram #(.WIDTH(9), .DEPTH(scsa_pkg::NUM_BUCKETS)) u_used (
      .clock(clock), .wr_en(wr_en), .wr_addr(used_wr_addr), .wr_data(used_wr),
      .rd_addr(slot), .rd_data(used_rd)
   );

   logic [7:0] aidx;
   assign aidx = {wrd_ff, found_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff[0] <= 9'd256; count_ff[1] <= 9'd256;
         count_ff[2] <= 9'd256; count_ff[3] <= 9'd128;
         count_ff[4] <= 9'd64;  count_ff[5] <= 9'd32;
         count_ff[6] <= 9'd16;  count_ff[7] <= 9'd4;
      end else begin
         if (csr_wr_en) count_ff[csr_index] <= csr_wdata;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == WA'(scsa_pkg::NUM_WORDS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  req_ff <= req_data;
                  cls_ff <= cls_res.cls;
                  bkt_ff <= '0;
                  wrd_ff <= '0;
                  if (cls_res.too_large) begin
                     rsp_ff <= '{scsa_pkg::ST_TOO_LARGE, 24'd0, 3'd0, 8'd0};
                     state_ff <= S_DONE;
                  end else state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               waddr_ff <= rd_addr;
               if (req_ff.command == scsa_pkg::CMD_FREE) begin
                  if (!fgood) begin
                     rsp_ff <= '{scsa_pkg::ST_BAD_ADDR, faddr, cls_ff, 8'd0};
                     state_ff <= S_DONE;
                  end else if (rd_data[fidx[5:0]]) begin
                     rsp_ff <= '{scsa_pkg::ST_DOUBLE_FREE, faddr, cls_ff, fidx};
                     state_ff <= S_DONE;
                  end else begin
                     wdata_ff <= rd_data | (64'd1 << fidx[5:0]);
                     rsp_ff <= '{scsa_pkg::ST_OK, faddr, cls_ff, fidx};
                     state_ff <= S_WRITE;
                  end
               end else if (found) begin
                  wdata_ff <= rd_data & ~(64'd1 << found_bit);
                  rsp_ff <= '{scsa_pkg::ST_OK,
                     24'(({19'd0, slot} << scsa_pkg::REGION_LOG2) +
                         ({16'd0, aidx} << (scsa_pkg::MIN_BLOCK_LOG2 + cls_ff))),
                     cls_ff, aidx};
                  state_ff <= S_WRITE;
               end else if (wrd_ff != scsa_pkg::WSEL_W'(scsa_pkg::WORDS_PER_BUCKET - 1)) begin
                  wrd_ff <= wrd_ff + 1'b1;
                  state_ff <= S_READ;
               end else if (bkt_ff != scsa_pkg::BSEL_W'(scsa_pkg::BUCKETS_PER_CLASS - 1)) begin
                  wrd_ff <= '0;
                  bkt_ff <= bkt_ff + 1'b1;
                  state_ff <= S_READ;
               end else begin
                  rsp_ff <= '{scsa_pkg::ST_NO_SPACE, 24'd0, cls_ff, 8'd0};
                  state_ff <= S_DONE;
               end
            end
            S_WRITE: state_ff <= S_DONE;
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_IMPL(a_no_accept_clear, clock, reset, state_ff == S_CLEAR, req_stall)
   `ASSERT_NEXT(a_done_valid, clock, reset, state_ff == S_DONE, rsp_valid_ff)
   `ASSERT_IMPL(a_busy_stall, clock, reset, rsp_valid_ff, req_stall)
endmodule
`default_nettype wire

/* src/scsa_ram.sv */
`default_nettype none
module scsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/scsa_classify.sv */
`default_nettype none
// Round length to alignment and pick the size class.
module scsa_classify (
   input  wire logic [15:0]          req_length,
   input  wire logic [3:0]           align_log2,
   output scsa_pkg::class_type       result
);
   logic [16:0] mask;
   logic [16:0] size;
   always_comb begin
      mask = (17'd1 << align_log2) - 17'd1;
      size = ({1'b0, req_length} + mask) & ~mask;
      result.too_large = 1'b1;
      result.cls = '0;
      for (int c = scsa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
         if (size <= (17'd1 << (scsa_pkg::MIN_BLOCK_LOG2 + c))) begin
            result.too_large = 1'b0;
            result.cls = 3'(c);
         end
      end
   end
endmodule
`default_nettype wire

/* bench/size_class_slab_allocator_unit_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module size_class_slab_allocator_unit_tb;

   // csr index names, one per size class
   typedef enum logic [2:0] {
      CSR_COUNT0, CSR_COUNT1, CSR_COUNT2, CSR_COUNT3,
      CSR_COUNT4, CSR_COUNT5, CSR_COUNT6, CSR_COUNT7
   } csr_index_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   scsa_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   scsa_pkg::rsp_type rsp_data;
   logic          csr_wr_en;
   logic [2:0]    csr_index;
   logic [8:0]    csr_wdata;

   size_class_slab_allocator_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // ------------------------------------------------------------------
   // Shadow allocator state
   // ------------------------------------------------------------------
   logic [8:0]   class_count [scsa_pkg::NUM_CLASSES];
   logic [255:0] free_map    [scsa_pkg::NUM_BUCKETS];   // 1 = block free
   scsa_pkg::rsp_type pending_rsp [$];                  // responses still owed
   int           error_count;
   bit           rx_idle_off;                 // no response-side stalls at the end
   bit           tx_idle_off;                 // no request gaps at the end

   // blocks per bucket after clamping to MAX_BLOCKS
   function automatic int blocks_in(int cls);
      int n;
      n = class_count[cls];
      return (n > scsa_pkg::MAX_BLOCKS) ? scsa_pkg::MAX_BLOCKS : n;
   endfunction

   // round the length to the alignment, pick the class; NUM_CLASSES = too large
   function automatic int pick_class(logic [15:0] len, logic [3:0] alog);
      longint align, rounded;
      int     c;
      align   = longint'(1) << alog;
      rounded = (longint'(len) + align - 1) & ~(align - 1);
      for (c = 0; c < scsa_pkg::NUM_CLASSES; c++)
         if (rounded <= (longint'(16) << c)) return c;
      return scsa_pkg::NUM_CLASSES;
   endfunction

   // apply one request to the shadow state and return the response it owes
   function automatic scsa_pkg::rsp_type allocate_or_free(scsa_pkg::req_type rq);
      scsa_pkg::rsp_type r;
      int      cls, n, b, i, slot, bsz;
      int      region, offset;
      bit      found;
      r     = '0;
      found = 0;
      cls   = pick_class(rq.req_length, rq.align_log2);
      if (cls >= scsa_pkg::NUM_CLASSES) begin
         r.status = scsa_pkg::ST_TOO_LARGE;
         return r;
      end
      r.size_class = cls[2:0];
      bsz = 16 << cls;
      n = blocks_in(cls);
      if (rq.command == scsa_pkg::CMD_ALLOC) begin
         r.status = scsa_pkg::ST_NO_SPACE;
         for (b = 0; b < scsa_pkg::BUCKETS_PER_CLASS && !found; b++) begin
            slot = cls * scsa_pkg::BUCKETS_PER_CLASS + b;
            for (i = 0; i < n && !found; i++) begin
               if (free_map[slot][i]) begin
                  free_map[slot][i] = 1'b0;
                  found             = 1;
                  r.status          = scsa_pkg::ST_OK;
                  r.block_index     = i[7:0];
                  r.block_address   = 24'((slot << scsa_pkg::REGION_LOG2) + i * bsz);
               end
            end
         end
      end else begin
         region          = rq.free_address >> scsa_pkg::REGION_LOG2;
         offset          = rq.free_address & ((1 << scsa_pkg::REGION_LOG2) - 1);
         i               = offset / bsz;
         r.block_address = rq.free_address;
         r.status        = scsa_pkg::ST_BAD_ADDR;
         if (region / scsa_pkg::BUCKETS_PER_CLASS == cls && offset % bsz == 0 && i < n) begin
            r.block_index = i[7:0];
            if (free_map[region][i]) begin
               r.status = scsa_pkg::ST_DOUBLE_FREE;
            end else begin
               free_map[region][i] = 1'b1;
               r.status            = scsa_pkg::ST_OK;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Clock, time limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side: random stall bursts, in-order checking
   // ------------------------------------------------------------------
   initial begin
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!rx_idle_off && $urandom_range(0, 9) == 0) begin
            burst     = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      scsa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.status, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.block_address !== want.block_address)
               report_mismatch("block_address", rsp_data.block_address,
                               want.block_address);
            if (rsp_data.size_class !== want.size_class)
               report_mismatch("size_class", rsp_data.size_class, want.size_class);
            if (rsp_data.block_index !== want.block_index)
               report_mismatch("block_index", rsp_data.block_index, want.block_index);
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // present one request, hold it until taken, then queue what it owes;
   // an optional typed-in status is cross-checked against the predictor
   task automatic send_request(scsa_pkg::req_type rq, int typed_status = -1);
      scsa_pkg::rsp_type r;
      int      gap;
      // valid was dropped at the previous falling edge; move past it
      @(negedge clock);
      if (!tx_idle_off && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         repeat (gap) @(negedge clock);
      end
      req_data  <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      r = allocate_or_free(rq);
      if (typed_status >= 0 && r.status != typed_status)
         report_mismatch("directed status", r.status, typed_status);
      pending_rsp.push_back(r);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // wait for every owed response, then let the block settle
   task automatic drain;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_count(csr_index_type idx, logic [8:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en          <= 1'b0;
      class_count[idx] = value;
      @(negedge clock);
   endtask

   // address of block i of bucket b of class c
   function automatic logic [23:0] block_addr(int c, int b, int i);
      return 24'(((c * scsa_pkg::BUCKETS_PER_CLASS + b) << scsa_pkg::REGION_LOG2) +
                 i * (16 << c));
   endfunction

   // random request: mostly frees of live blocks and well-sized allocs
   function automatic scsa_pkg::req_type random_request(int len_cap);
      scsa_pkg::req_type rq;
      int      c, b, i;
      rq              = '0;
      rq.command      = 1'($urandom_range(0, 1));
      rq.align_log2   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 6));
      rq.req_length   = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, len_cap));
      rq.free_address = 24'($urandom);
      if (rq.command == scsa_pkg::CMD_FREE && $urandom_range(0, 9) < 8) begin
         c  = $urandom_range(0, scsa_pkg::NUM_CLASSES - 1);
         b  = $urandom_range(0, scsa_pkg::BUCKETS_PER_CLASS - 1);
         i  = $urandom_range(0, 7);
         // mostly aim at a block still in use
         for (int k = 0; k < 256; k++)
            if (!free_map[c * scsa_pkg::BUCKETS_PER_CLASS + b][k] &&
                $urandom_range(0, 3) == 0) begin
               i = k;
               break;
            end
         rq.free_address = 24'(block_addr(c, b, i) +
                               (($urandom_range(0, 15) == 0) ? 8 : 0));
         rq.req_length   = 16'((16 << c) - $urandom_range(0, 7));
         rq.align_log2   = 4'd0;
      end
      return rq;
   endfunction

   // directed rows; status typed in where obvious, -1 = predictor only
   typedef struct {
      logic        command;
      logic [15:0] req_length;
      logic [3:0]  align_log2;
      logic [23:0] free_address;
      int          typed_status;
   } stim_row_type;

   stim_row_type directed_rows [] = '{
      '{scsa_pkg::CMD_ALLOC, 16'd0,    4'd0,  24'h0,      scsa_pkg::ST_OK}, // zero length
      '{scsa_pkg::CMD_ALLOC, 16'd16,   4'd0,  24'h0,      scsa_pkg::ST_OK},
      '{scsa_pkg::CMD_ALLOC, 16'd17,   4'd0,  24'h0,      scsa_pkg::ST_OK}, // class 1
      '{scsa_pkg::CMD_ALLOC, 16'd2048, 4'd0,  24'h0,      scsa_pkg::ST_OK}, // largest class
      '{scsa_pkg::CMD_ALLOC, 16'd2049, 4'd0,  24'h0,      scsa_pkg::ST_TOO_LARGE},
      '{scsa_pkg::CMD_ALLOC, 16'hFFFF, 4'd15, 24'hFFFFFF, scsa_pkg::ST_TOO_LARGE},
      '{scsa_pkg::CMD_ALLOC, 16'd1,    4'd11, 24'h0,      scsa_pkg::ST_OK}, // align to 2048
      '{scsa_pkg::CMD_ALLOC, 16'd1,    4'd12, 24'h0,      scsa_pkg::ST_TOO_LARGE},
      '{scsa_pkg::CMD_FREE,  16'd16,   4'd0,  24'h000000, scsa_pkg::ST_OK},
      '{scsa_pkg::CMD_FREE,  16'd16,   4'd0,  24'h000000, scsa_pkg::ST_DOUBLE_FREE},
      // not at block start
      '{scsa_pkg::CMD_FREE,  16'd16,   4'd0,  24'h000008, scsa_pkg::ST_BAD_ADDR},
      // other class region
      '{scsa_pkg::CMD_FREE,  16'd16,   4'd0,  24'h200000, scsa_pkg::ST_BAD_ADDR},
      // index past count
      '{scsa_pkg::CMD_FREE,  16'd16,   4'd0,  24'h001000, scsa_pkg::ST_BAD_ADDR},
      '{scsa_pkg::CMD_FREE,  16'd2048, 4'd0,  24'hE00000, scsa_pkg::ST_OK},
      // last bucket
      '{scsa_pkg::CMD_FREE,  16'd2048, 4'd0,  24'hF80000, scsa_pkg::ST_DOUBLE_FREE},
      '{scsa_pkg::CMD_FREE,  16'hFFFF, 4'd0,  24'hFFFFFF, scsa_pkg::ST_TOO_LARGE},
      '{scsa_pkg::CMD_FREE,  16'd32,   4'd15, 24'h080000, scsa_pkg::ST_TOO_LARGE},
      '{scsa_pkg::CMD_ALLOC, 16'd100,  4'd3,  24'h0,      -1},
      '{scsa_pkg::CMD_FREE,  16'd17,   4'd0,  24'h200000, -1}
   };

   initial begin
      scsa_pkg::req_type rq;
      int      c, phase, cap;
      error_count = 0;
      rx_idle_off = 0;
      tx_idle_off = 0;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_COUNT0;
      csr_wdata   = '0;
      class_count = '{9'd256, 9'd256, 9'd256, 9'd128, 9'd64, 9'd32, 9'd16, 9'd4};
      foreach (free_map[s]) free_map[s] = '1;
      reset = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k]) begin
         rq.command      = directed_rows[k].command;
         rq.req_length   = directed_rows[k].req_length;
         rq.align_log2   = directed_rows[k].align_log2;
         rq.free_address = directed_rows[k].free_address;
         send_request(rq, directed_rows[k].typed_status);
      end
      // sender holds off until the pipeline is empty
      drain();

      // phases of counts: tiny (hits no space), max and over-max, small random, random
      for (phase = 0; phase < 4; phase++) begin
         for (c = 0; c < scsa_pkg::NUM_CLASSES; c++) begin
            case (phase)
               0: write_count(csr_index_type'(c), 9'd1);
               1: write_count(csr_index_type'(c), 9'd511);
               2: write_count(csr_index_type'(c), 9'($urandom_range(1, 8)));
               default: write_count(csr_index_type'(c), 9'($urandom_range(0, 300)));
            endcase
         end
         if (phase == 3) tx_idle_off = 1;
         if (phase == 3) rx_idle_off = 1;
         cap = (phase == 1) ? 2600 : 600;
         for (int k = 0; k < 150; k++) begin
            rq = random_request(cap);
            send_request(rq);
         end
         drain();
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
